// File: src/dstq_pkg.sv
// ----------------------------------------------------------------------------
// Deadline-sorted timer queue package
// Request and response types, entry layout and status codes.
// ----------------------------------------------------------------------------
package dstq_pkg;

	localparam logic KIND_ADD  = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	localparam logic [1:0] ST_ADDED   = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_EXPIRED = 2'd2;
	localparam logic [1:0] ST_NONE    = 2'd3;

	localparam int MAX_POP = 16;
	localparam int POP_W   = 5;

	typedef struct packed {
		logic        kind;
		logic [15:0] tag;
		logic [31:0] start_req;
		logic [30:0] interval;
		logic [31:0] now;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] expired_tag;
		logic        last;
	} rsp_t;

	typedef struct packed {
		logic [31:0] start;
		logic [30:0] interval;
		logic [15:0] tag;
		logic [31:0] deadline;
	} entry_t;

endpackage

// File: src/deadline_sorted_timer_queue.sv
// ----------------------------------------------------------------------------
// Deadline-sorted timer queue
// Keeps up to DEPTH timers sorted by wrap-aware deadline in one synchronous
// memory used as a ring; adds insert in order, ticks pop expired head timers.
// ----------------------------------------------------------------------------
// An add request compares held timers in order until the insert point is found,
// then moves each later timer up by one place and writes the new timer; a full
// queue answers an add with the full status and changes nothing. A tick pops
// expired timers from the head, at most 16 per tick. The single registered read
// port of the entry memory sets the pace: the scan and the shift visit one entry
// per cycle. A response register that is still full and not taken stalls the
// queue between popped timers and before a request completes.
// The response register lets a new request be taken while the last response
// still waits.
module deadline_sorted_timer_queue
	import dstq_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_ACHK  = 3'd1;
	localparam logic [2:0] S_SHIFT = 3'd2;
	localparam logic [2:0] S_AINS  = 3'd3;
	localparam logic [2:0] S_TCHK  = 3'd4;
	localparam logic [2:0] S_FIN   = 3'd5;

	entry_t mem [DEPTH];
	entry_t rd_q;

	logic [2:0]       state_q, state_d;
	logic [PW-1:0]    head_q, head_d;
	logic [CW-1:0]    count_q, count_d;
	logic [PW-1:0]    scan_q, scan_d;
	logic [CW-1:0]    pos_q, pos_d;
	logic [POP_W-1:0] pop_cnt_q, pop_cnt_d;
	entry_t           new_q, new_d;
	logic [31:0]      now_q, now_d;
	logic             hold_valid_q, hold_valid_d;
	logic [1:0]       hold_status_q, hold_status_d;
	logic [15:0]      hold_tag_q, hold_tag_d;
	logic             rsp_valid_q, rsp_valid_d;
	rsp_t             rsp_q, rsp_d;

	logic          rd_en, wr_en, push, pop;
	logic [PW-1:0] rd_lidx, wr_lidx, rd_addr, wr_addr;
	entry_t        wr_data;
	rsp_t          push_data;
	logic          later, expired, slot_free;
	logic [31:0]   dl_diff, age;

	function automatic logic [PW-1:0] phys(input logic [PW-1:0] head, input logic [PW-1:0] lidx);
		logic [PW:0] s;
		s = {1'b0, head} + {1'b0, lidx};
		if (s >= (PW+1)'(DEPTH)) begin
			s = s - (PW+1)'(DEPTH);
		end
		return s[PW-1:0];
	endfunction

	assign rd_addr   = phys(head_q, rd_lidx);
	assign wr_addr   = phys(head_q, wr_lidx);
	assign dl_diff   = new_q.deadline - rd_q.deadline;
	assign later     = dl_diff[31];
	assign age       = now_q - rd_q.start;
	assign expired   = age >= {1'b0, rd_q.interval};
	assign slot_free = !rsp_valid_q || rsp_ready;
	assign pop       = (state_q == S_TCHK) && (count_q != '0) &&
		(pop_cnt_q != POP_W'(MAX_POP)) && expired && (!hold_valid_q || slot_free);

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		state_d       = state_q;
		head_d        = head_q;
		count_d       = count_q;
		scan_d        = scan_q;
		pos_d         = pos_q;
		pop_cnt_d     = pop_cnt_q;
		new_d         = new_q;
		now_d         = now_q;
		hold_valid_d  = hold_valid_q;
		hold_status_d = hold_status_q;
		hold_tag_d    = hold_tag_q;
		rd_en         = 1'b0;
		rd_lidx       = '0;
		wr_en         = 1'b0;
		wr_lidx       = '0;
		wr_data       = new_q;
		push          = 1'b0;
		push_data     = '0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					hold_valid_d   = 1'b0;
					pop_cnt_d      = '0;
					scan_d         = '0;
					new_d.start    = req.start_req;
					new_d.interval = req.interval;
					new_d.tag      = req.tag;
					new_d.deadline = req.start_req + {1'b0, req.interval};
					now_d          = req.now;
					if (req.kind == KIND_TICK) begin
						rd_en   = 1'b1;
						state_d = S_TCHK;
					end else if (count_q == CW'(DEPTH)) begin
						hold_valid_d  = 1'b1;
						hold_status_d = ST_FULL;
						hold_tag_d    = '0;
						state_d       = S_FIN;
					end else if (count_q == '0) begin
						pos_d   = '0;
						state_d = S_AINS;
					end else begin
						rd_en   = 1'b1;
						state_d = S_ACHK;
					end
				end
			end
			S_ACHK: begin
				if (later) begin
					pos_d   = CW'(scan_q);
					rd_en   = 1'b1;
					rd_lidx = PW'(count_q - 1'b1);
					scan_d  = PW'(count_q);
					state_d = S_SHIFT;
				end else if (CW'(scan_q) + 1'b1 == count_q) begin
					pos_d   = count_q;
					state_d = S_AINS;
				end else begin
					rd_en   = 1'b1;
					rd_lidx = scan_q + 1'b1;
					scan_d  = scan_q + 1'b1;
				end
			end
			S_SHIFT: begin
				wr_en   = 1'b1;
				wr_lidx = scan_q;
				wr_data = rd_q;
				if (CW'(scan_q - 1'b1) == pos_q) begin
					state_d = S_AINS;
				end else begin
					rd_en   = 1'b1;
					rd_lidx = scan_q - PW'(2);
					scan_d  = scan_q - 1'b1;
				end
			end
			S_AINS: begin
				wr_en         = 1'b1;
				wr_lidx       = PW'(pos_q);
				count_d       = count_q + 1'b1;
				hold_valid_d  = 1'b1;
				hold_status_d = ST_ADDED;
				hold_tag_d    = '0;
				state_d       = S_FIN;
			end
			S_TCHK: begin
				if (pop) begin
					if (hold_valid_q) begin
						push      = 1'b1;
						push_data = '{status: hold_status_q, expired_tag: hold_tag_q, last: 1'b0};
					end
					hold_valid_d  = 1'b1;
					hold_status_d = ST_EXPIRED;
					hold_tag_d    = rd_q.tag;
					head_d        = (head_q == PW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
					count_d       = count_q - 1'b1;
					pop_cnt_d     = pop_cnt_q + 1'b1;
					rd_en         = 1'b1;
					rd_lidx       = PW'(1);
				end else if ((count_q == '0) || (pop_cnt_q == POP_W'(MAX_POP)) || !expired) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (slot_free) begin
					push = 1'b1;
					if (hold_valid_q) begin
						push_data = '{status: hold_status_q, expired_tag: hold_tag_q, last: 1'b1};
					end else begin
						push_data = '{status: ST_NONE, expired_tag: 16'd0, last: 1'b1};
					end
					hold_valid_d = 1'b0;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (push) begin
			rsp_valid_d = 1'b1;
			rsp_d       = push_data;
		end else begin
			rsp_valid_d = rsp_valid_q && !rsp_ready;
			rsp_d       = rsp_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			head_q       <= '0;
			count_q      <= '0;
			pop_cnt_q    <= '0;
			hold_valid_q <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			head_q       <= head_d;
			count_q      <= count_d;
			pop_cnt_q    <= pop_cnt_d;
			hold_valid_q <= hold_valid_d;
			rsp_valid_q  <= rsp_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		scan_q        <= scan_d;
		pos_q         <= pos_d;
		new_q         <= new_d;
		now_q         <= now_d;
		hold_status_q <= hold_status_d;
		hold_tag_q    <= hold_tag_d;
		rsp_q         <= rsp_d;
	end

`ifndef NO_ASSERTIONS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("Timer count exceeds the queue depth.");

	a_insert_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_AINS) |-> (count_q < CW'(DEPTH)))
		else $error("Insert started on a full queue.");

	a_shift_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHIFT) |-> (CW'(scan_q) > pos_q))
		else $error("Shift reached below the insert position.");

	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (count_q == $past(count_q) - 1'b1))
		else $error("Pop did not reduce the timer count by one.");
`endif

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deadline-sorted timer queue testbench
// Sends add and tick requests through the valid/ready channels with random
// gaps, stalls and one long response hold-off. A sorted copy of the timer list
// predicts every response, and each response is compared field by field.
// ----------------------------------------------------------------------------
module testbench;
	import dstq_pkg::*;

	localparam int DEPTH          = 16;
	localparam int DIRECTED_COUNT = 22;
	localparam int RANDOM_COUNT   = 140;
	localparam int LONG_HOLD_AT   = 100;
	localparam int LONG_HOLD_LEN  = 400;
	localparam int PAUSE_AT       = 120;

	class timer_list_board;
		logic [31:0] held_start [DEPTH];
		logic [30:0] held_interval [DEPTH];
		logic [15:0] held_tag [DEPTH];
		int held_count;
		rsp_t pending_rsps [$];
		int error_count;
		int request_count;
		int response_count;
		int expiry_count;
		int drop_count;

		function rsp_t make_rsp(logic [1:0] status, logic [15:0] expired_tag, logic last);
			rsp_t r;
			r.status = status;
			r.expired_tag = expired_tag;
			r.last = last;
			return r;
		endfunction

		function int pending_count();
			return pending_rsps.size();
		endfunction

		function void note_request(req_t item);
			logic [31:0] deadline;
			logic [31:0] other;
			logic [31:0] diff;
			logic [31:0] age;
			logic [15:0] popped [$];
			int slot;
			int i;
			request_count++;
			if (item.kind == KIND_ADD) begin
				if (held_count >= DEPTH) begin
					pending_rsps.push_back(make_rsp(ST_FULL, 16'h0, 1'b1));
					return;
				end
				deadline = item.start_req + {1'b0, item.interval};
				slot = held_count;
				for (i = 0; i < held_count; i++) begin
					other = held_start[i] + {1'b0, held_interval[i]};
					diff = deadline - other;
					if (diff[31]) begin
						slot = i;
						break;
					end
				end
				for (i = held_count; i > slot; i--) begin
					held_start[i] = held_start[i - 1];
					held_interval[i] = held_interval[i - 1];
					held_tag[i] = held_tag[i - 1];
				end
				held_start[slot] = item.start_req;
				held_interval[slot] = item.interval;
				held_tag[slot] = item.tag;
				held_count++;
				pending_rsps.push_back(make_rsp(ST_ADDED, 16'h0, 1'b1));
			end else begin
				while (held_count > 0 && popped.size() < MAX_POP) begin
					age = item.now - held_start[0];
					if (age < {1'b0, held_interval[0]})
						break;
					popped.push_back(held_tag[0]);
					for (i = 1; i < held_count; i++) begin
						held_start[i - 1] = held_start[i];
						held_interval[i - 1] = held_interval[i];
						held_tag[i - 1] = held_tag[i];
					end
					held_count--;
				end
				if (popped.size() == 0)
					pending_rsps.push_back(make_rsp(ST_NONE, 16'h0, 1'b1));
				for (i = 0; i < popped.size(); i++)
					pending_rsps.push_back(make_rsp(ST_EXPIRED, popped[i],
						i == popped.size() - 1));
			end
		endfunction

		function void check_response(rsp_t got);
			rsp_t want;
			response_count++;
			if (pending_rsps.size() == 0) begin
				$error("unexpected response: status %0d, expired_tag %h, last %0d",
					got.status, got.expired_tag, got.last);
				error_count++;
				return;
			end
			want = pending_rsps.pop_front();
			if (want.status == ST_EXPIRED)
				expiry_count++;
			if (want.status == ST_FULL)
				drop_count++;
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				error_count++;
			end
			if (got.expired_tag !== want.expired_tag) begin
				$error("expired_tag: expected %h, got %h", want.expired_tag, got.expired_tag);
				error_count++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0d, got %0d", want.last, got.last);
				error_count++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	timer_list_board board;
	int sender_gap_max = 14;
	logic [31:0] clock_now;

	deadline_sorted_timer_queue #(
		.DEPTH(DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic req_t random_req();
		logic [127:0] bits;
		bits = {$urandom(), $urandom(), $urandom(), $urandom()};
		return bits[$bits(req_t)-1:0];
	endfunction

	function automatic req_t add_item(logic [15:0] tag, logic [31:0] start_req,
		logic [30:0] interval);
		req_t item;
		item = '0;
		item.kind = KIND_ADD;
		item.tag = tag;
		item.start_req = start_req;
		item.interval = interval;
		return item;
	endfunction

	function automatic req_t tick_item(logic [31:0] now);
		req_t item;
		item = '0;
		item.kind = KIND_TICK;
		item.now = now;
		return item;
	endfunction

	function automatic req_t fresh_add();
		req_t item;
		item = random_req();
		item.kind = KIND_ADD;
		item.start_req = clock_now - $urandom_range(0, 20);
		item.interval = 31'($urandom_range(0, 300));
		return item;
	endfunction

	function automatic req_t fresh_tick(int advance);
		req_t item;
		item = random_req();
		clock_now = clock_now + advance;
		item.kind = KIND_TICK;
		item.now = clock_now;
		return item;
	endfunction

	task automatic send_request(input req_t item);
		int gap;
		gap = $urandom_range(0, sender_gap_max);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req <= item;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		board.note_request(item);
	endtask

	task automatic wait_for_drain();
		req_valid <= 1'b0;
		do @(posedge clk); while (board.pending_count() > 0);
	endtask

	initial begin
		int k;
		int choice;
		bit paused;
		req_t item;
		board = new;
		paused = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(tick_item(32'h0));
		send_request(add_item(16'h0000, 32'h0, 31'h0));
		send_request(add_item(16'hFFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF));
		send_request(tick_item(32'h0));
		for (k = 0; k < 15; k++) begin
			if (k == 7)
				send_request(add_item(16'(16'h0100 + k), 32'hFFFF_FFF0, 31'h20));
			else
				send_request(add_item(16'(16'h0100 + k), 32'h1000 - k,
					31'((k % 5) * 8 + k)));
		end
		send_request(add_item(16'hBEEF, 32'h0, 31'h1));
		send_request(tick_item(32'h7FFF_FFFE));
		send_request(tick_item(32'h7FFF_FFFF));

		clock_now = 32'hFFFF_F000;
		while (board.request_count < DIRECTED_COUNT + RANDOM_COUNT) begin
			sender_gap_max = ((board.request_count / 40) % 2 != 0) ? 0 : 14;
			if (!paused && board.request_count >= PAUSE_AT) begin
				wait_for_drain();
				paused = 1'b1;
			end
			choice = $urandom_range(0, 99);
			if (choice < 50) begin
				send_request(fresh_add());
			end else if (choice < 80) begin
				send_request(fresh_tick($urandom_range(0, 60)));
			end else if (choice < 85) begin
				item = random_req();
				item.kind = KIND_ADD;
				send_request(item);
			end else if (choice < 90) begin
				item = random_req();
				item.kind = KIND_TICK;
				send_request(item);
			end else begin
				while (board.held_count < DEPTH)
					send_request(fresh_add());
				send_request(fresh_add());
				send_request(fresh_tick(1000));
			end
		end

		wait_for_drain();
		repeat (40) @(posedge clk);
		$display("Covered %0d requests and %0d responses: %0d timer expiries, %0d adds dropped",
			board.request_count, board.response_count, board.expiry_count, board.drop_count);
		$display("on a full queue, with wrapping time, a long response hold-off and a drain pause.");
		if (board.error_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		int stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (board.response_count == LONG_HOLD_AT)
				stall = LONG_HOLD_LEN;
			else
				stall = $urandom_range(0, ((board.response_count / 50) % 2 != 0) ? 0 : 14);
			if (stall > 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!rsp_valid);
			board.check_response(rsp);
		end
	end

	initial begin
		#1_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
